// ----- rtl/ssm_pkg.sv -----
// Shared types and constants for the sorted sequence merge block.
package ssm_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int REQ_W          = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MERGE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PICK
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic              last;
    logic              flag;
  } emit_t;

endpackage

// ----- rtl/ssm_store.sv -----
// Single-port-write, registered-read element store for one list.
module ssm_store #(
  parameter int LIST_DEPTH = ssm_pkg::LIST_DEPTH_DEF,
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [ssm_pkg::DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [ssm_pkg::DATA_W-1:0] rd_data
);

  logic [ssm_pkg::DATA_W-1:0] mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/ssm_ctrl.sv -----
// Merge sequencer: list counts, read pointers and the shared signed comparator.
module ssm_ctrl #(
  parameter int LIST_DEPTH = ssm_pkg::LIST_DEPTH_DEF,
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssm_pkg::REQ_W-1:0]   req_type,
  input  logic signed [ssm_pkg::DATA_W-1:0] element,
  output logic                        we_a,
  output logic                        we_b,
  output logic [ADDR_W-1:0]           wr_addr_a,
  output logic [ADDR_W-1:0]           wr_addr_b,
  output logic [ssm_pkg::DATA_W-1:0]  wr_data,
  output logic [ADDR_W-1:0]           rd_addr_a,
  output logic [ADDR_W-1:0]           rd_addr_b,
  input  logic [ssm_pkg::DATA_W-1:0]  rd_a,
  input  logic [ssm_pkg::DATA_W-1:0]  rd_b,
  input  logic                        out_free,
  output ssm_pkg::emit_t              emit
);

  localparam int TOT_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  ssm_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count_a, count_a_next;
  logic [CNT_W-1:0] count_b, count_b_next;
  logic [CNT_W-1:0] pa, pa_next;
  logic [CNT_W-1:0] pb, pb_next;
  logic             drop_flag, drop_flag_next;

  logic             acc;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] done_k;
  logic             a_empty;
  logic             b_empty;
  logic             take_a;
  logic             fire;

  assign in_stall  = (state != ssm_pkg::ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign total     = {1'b0, count_a} + {1'b0, count_b};
  assign done_k    = {1'b0, pa} + {1'b0, pb} + TOT_W'(1);
  assign a_empty   = (pa >= count_a);
  assign b_empty   = (pb >= count_b);
  assign take_a    = b_empty || (!a_empty && ($signed(rd_b) > $signed(rd_a)));
  assign fire      = (state == ssm_pkg::ST_PICK) && out_free;

  assign wr_addr_a = count_a[ADDR_W-1:0];
  assign wr_addr_b = count_b[ADDR_W-1:0];
  assign wr_data   = element;
  assign rd_addr_a = pa[ADDR_W-1:0];
  assign rd_addr_b = pb[ADDR_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssm_pkg::ST_IDLE: begin
        if (acc && (req_type == ssm_pkg::REQ_MERGE) && (total != '0)) begin
          state_next = ssm_pkg::ST_FETCH;
        end
      end
      ssm_pkg::ST_FETCH: begin
        state_next = ssm_pkg::ST_PICK;
      end
      ssm_pkg::ST_PICK: begin
        if (out_free) begin
          state_next = (done_k == total) ? ssm_pkg::ST_IDLE : ssm_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = ssm_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    we_a           = 1'b0;
    we_b           = 1'b0;
    count_a_next   = count_a;
    count_b_next   = count_b;
    pa_next        = pa;
    pb_next        = pb;
    drop_flag_next = drop_flag;
    emit.valid     = fire;
    emit.value     = take_a ? rd_a : rd_b;
    emit.last      = (done_k == total);
    emit.flag      = drop_flag;
    unique case (state)
      ssm_pkg::ST_IDLE: begin
        pa_next = '0;
        pb_next = '0;
        if (acc) begin
          case (req_type)
            ssm_pkg::REQ_APPEND_A: begin
              if (count_a < FULL) begin
                we_a         = 1'b1;
                count_a_next = count_a + CNT_W'(1);
              end else begin
                drop_flag_next = 1'b1;
              end
            end
            ssm_pkg::REQ_APPEND_B: begin
              if (count_b < FULL) begin
                we_b         = 1'b1;
                count_b_next = count_b + CNT_W'(1);
              end else begin
                drop_flag_next = 1'b1;
              end
            end
            ssm_pkg::REQ_MERGE: begin
              if (total == '0) begin
                drop_flag_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ssm_pkg::ST_FETCH: begin
      end
      ssm_pkg::ST_PICK: begin
        if (fire) begin
          if (take_a) begin
            pa_next = pa + CNT_W'(1);
          end else begin
            pb_next = pb + CNT_W'(1);
          end
          if (done_k == total) begin
            count_a_next   = '0;
            count_b_next   = '0;
            pa_next        = '0;
            pb_next        = '0;
            drop_flag_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssm_pkg::ST_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      pa        <= '0;
      pb        <= '0;
      drop_flag <= 1'b0;
    end else begin
      state     <= state_next;
      count_a   <= count_a_next;
      count_b   <= count_b_next;
      pa        <= pa_next;
      pb        <= pb_next;
      drop_flag <= drop_flag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (pa <= count_a) && (pb <= count_b))
    else $error("read pointer beyond list count");

  a_pick_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == ssm_pkg::ST_PICK) |-> (!a_empty || !b_empty))
    else $error("pick with both lists exhausted");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && emit.last) |=> (state == ssm_pkg::ST_IDLE) && (count_a == '0)
                            && (count_b == '0) && !drop_flag)
    else $error("merge end did not clear the lists");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (count_a <= FULL) && (count_b <= FULL))
    else $error("list count exceeds depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    we_a |=> (count_a == $past(count_a) + CNT_W'(1)))
    else $error("append to list A did not advance its count");
`endif

endmodule

// ----- rtl/sorted_sequence_merge.sv -----
// Top level of the two-way merge: list stores, merge sequencer and output register.
// Append requests (list A or list B) do not stall the input; an append to a full list
// is dropped and flagged on every result of the next merge. A merge request is taken
// and then emits each stored element through the ST_FETCH state for the registered
// store read and the ST_PICK state for the signed compare and select, so a merge
// keeps the input stalled until its final result is emitted, also while the output
// stalls. Ties go to list B. A merge of two empty lists emits nothing. Results
// leave through an output register, so the input is ready again while the final
// result of a merge still waits to be taken.
module sorted_sequence_merge #(
  parameter int LIST_DEPTH = ssm_pkg::LIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ssm_pkg::REQ_W-1:0]         req_type,
  input  logic signed [ssm_pkg::DATA_W-1:0] element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ssm_pkg::DATA_W-1:0] merged_value,
  output logic                              last_of_run,
  output logic                              overflowed
);

  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                       we_a;
  logic                       we_b;
  logic [ADDR_W-1:0]          wr_addr_a;
  logic [ADDR_W-1:0]          wr_addr_b;
  logic [ssm_pkg::DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0]          rd_addr_a;
  logic [ADDR_W-1:0]          rd_addr_b;
  logic [ssm_pkg::DATA_W-1:0] rd_a;
  logic [ssm_pkg::DATA_W-1:0] rd_b;
  logic                       out_free;
  ssm_pkg::emit_t             emit;

  assign out_free = !out_valid || !out_stall;

  ssm_store #(.LIST_DEPTH(LIST_DEPTH)) u_store_a (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (wr_addr_a),
    .wr_data (wr_data),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  ssm_store #(.LIST_DEPTH(LIST_DEPTH)) u_store_b (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (wr_addr_b),
    .wr_data (wr_data),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  ssm_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .element   (element),
    .we_a      (we_a),
    .we_b      (we_b),
    .wr_addr_a (wr_addr_a),
    .wr_addr_b (wr_addr_b),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .out_free  (out_free),
    .emit      (emit)
  );

  // hold the result until its transfer, load the next one when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      merged_value <= emit.value;
      last_of_run  <= emit.last;
      overflowed   <= emit.flag;
    end
  end

endmodule
